// ===== hdl/fpt_pkg.sv =====
// ----------------------------------------------------------------------------
// fpt_pkg
// shared types and constants of the float placement table
// ----------------------------------------------------------------------------
package fpt_pkg;

	localparam int MAX_FLOATS = 16;
	localparam int IDX_BITS   = $clog2(MAX_FLOATS);
	localparam int CNT_BITS   = $clog2(MAX_FLOATS + 1);

	localparam logic [2:0] KIND_EMPTY  = 3'd0;
	localparam logic [2:0] KIND_PLACE  = 3'd1;
	localparam logic [2:0] KIND_BAND   = 3'd2;
	localparam logic [2:0] KIND_CLEAR  = 3'd3;
	localparam logic [2:0] KIND_BOTTOM = 3'd4;

	localparam logic CFG_LEFT  = 1'b0;
	localparam logic CFG_RIGHT = 1'b1;

	typedef struct packed {
		logic signed [31:0] x0;
		logic signed [31:0] x1;
		logic signed [31:0] y0;
		logic signed [31:0] y1;
		logic               right;
	} fbox_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] y;
		logic signed [31:0] ph;
		logic signed [31:0] bw;
		logic signed [31:0] bh;
		logic signed [31:0] ml;
		logic signed [31:0] mr;
		logic signed [31:0] mt;
		logic signed [31:0] mb;
		logic               right;
		logic [1:0]         mask;
	} item_t;

	typedef struct packed {
		logic signed [31:0] band_left;
		logic signed [31:0] band_right;
		logic signed [31:0] edge_y;
		logic signed [31:0] place_x;
		logic signed [31:0] place_y;
		logic               recorded;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture item, prepare derived values
		logic scan_start; // reset accumulators, index 0
		logic scan_step;  // process one entry
		logic fit_check;  // width test step after a band scan
		logic advance;    // move at to next candidate
		logic finish;     // form result, append if place
		logic clear_cnt;  // empty table
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] kind;
		logic       scan_last;
		logic       fits;
		logic       no_next;
		logic       tries_done;
	} stat_t;

endpackage

// ===== hdl/fpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpt_ctrl
// sequencer for table scans and placement tries
// ----------------------------------------------------------------------------
module fpt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic           out_busy,
	input  fpt_pkg::stat_t st,
	output fpt_pkg::cmd_t  cmd,
	output logic           idle,
	output logic           res_set
);

	typedef enum logic [2:0] {S_IDLE, S_DEC, S_SCAN, S_CHECK, S_FIN, S_WAIT} state_t;
	state_t state_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		case (state_q)
			S_DEC: begin
				if (st.kind == fpt_pkg::KIND_EMPTY) cmd.clear_cnt = 1'b1;
				cmd.scan_start = 1'b1;
			end
			S_SCAN:  cmd.scan_step = 1'b1;
			S_CHECK: begin
				cmd.fit_check = 1'b1;
				if (!(st.fits || st.no_next || st.tries_done)) cmd.advance = 1'b1;
			end
			S_FIN:   cmd.finish = 1'b1;
			default: ;
		endcase
		if (state_q == S_CHECK && cmd.advance) cmd.scan_start = 1'b1;
	end

	assign idle    = (state_q == S_IDLE);
	assign res_set = (state_q == S_FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_DEC;
				S_DEC: begin
					if (st.kind == fpt_pkg::KIND_PLACE || st.kind == fpt_pkg::KIND_BAND ||
					    st.kind == fpt_pkg::KIND_CLEAR || st.kind == fpt_pkg::KIND_BOTTOM)
						state_q <= S_SCAN;
					else
						state_q <= S_FIN;
				end
				S_SCAN: if (st.scan_last)
					state_q <= (st.kind == fpt_pkg::KIND_PLACE) ? S_CHECK : S_FIN;
				S_CHECK: begin
					if (st.fits || st.no_next || st.tries_done) state_q <= S_FIN;
					else state_q <= S_SCAN;
				end
				S_FIN:  state_q <= S_WAIT;
				S_WAIT: if (!out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_fin_after: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> state_q == S_WAIT) else $error("fin not followed by wait");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == S_IDLE) else $error("load while busy");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.scan_step, cmd.fit_check, cmd.finish})) else $error("cmd clash");

endmodule

// ===== hdl/fpt_dp.sv =====
// ----------------------------------------------------------------------------
// fpt_dp
// float table storage, scan accumulators and result forming
// ----------------------------------------------------------------------------
module fpt_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  fpt_pkg::cmd_t       cmd,
	input  fpt_pkg::item_t      item,
	input  logic                cfg_en,
	input  logic                cfg_addr,
	input  logic signed [31:0]  cfg_data,
	output fpt_pkg::stat_t      st,
	output fpt_pkg::result_t    res
);

	fpt_pkg::fbox_t mem [fpt_pkg::MAX_FLOATS];
	fpt_pkg::fbox_t rd_q;
	fpt_pkg::item_t it_q;
	fpt_pkg::result_t res_c;

	logic signed [31:0] cl_q, cr_q;
	logic [fpt_pkg::CNT_BITS-1:0] cnt_q, idx_q, tries_q;
	logic rd_vld_q;
	logic signed [31:0] ow_q, oh_q, at_q, yend_q;
	logic signed [31:0] lo_q, hi_q, mx_q, nxt_q;

	// band height, at least one
	logic signed [31:0] h_raw, h_eff;
	assign h_raw = (it_q.kind == fpt_pkg::KIND_PLACE) ? oh_q : it_q.ph;
	assign h_eff = (h_raw < 32'sd1) ? 32'sd1 : h_raw;

	// a new scan always starts at entry 0
	logic [fpt_pkg::CNT_BITS-1:0] rd_idx;
	assign rd_idx = cmd.scan_start ? '0 : idx_q;

	logic rd_go;
	assign rd_go = (cmd.scan_start || cmd.scan_step) && !cmd.clear_cnt && rd_idx < cnt_q;

	always_ff @(posedge clk) begin
		if (rd_go) rd_q <= mem[rd_idx[fpt_pkg::IDX_BITS-1:0]];
	end

	logic signed [31:0] hi_c, px_c, wid_c;
	assign hi_c  = (hi_q < lo_q) ? lo_q : hi_q;
	assign wid_c = hi_c - lo_q;
	assign px_c  = it_q.right ? (hi_c - ow_q + it_q.ml) : (lo_q + it_q.ml);

	logic want;
	assign want = rd_q.right ? it_q.mask[1] : it_q.mask[0];

	always_comb begin
		res_c = '0;
		case (it_q.kind)
			fpt_pkg::KIND_BAND: begin
				res_c.band_left  = lo_q;
				res_c.band_right = hi_c;
			end
			fpt_pkg::KIND_CLEAR, fpt_pkg::KIND_BOTTOM: res_c.edge_y = mx_q;
			fpt_pkg::KIND_PLACE: begin
				res_c.place_x  = px_c;
				res_c.place_y  = at_q + it_q.mt;
				res_c.recorded = (cnt_q < fpt_pkg::CNT_BITS'(fpt_pkg::MAX_FLOATS));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			it_q <= item;
			ow_q <= item.bw + item.ml + item.mr;
			oh_q <= item.bh + item.mt + item.mb;
		end
		if (cmd.scan_start) begin
			lo_q   <= cl_q;
			hi_q   <= cr_q;
			mx_q   <= (it_q.kind == fpt_pkg::KIND_CLEAR) ? it_q.y : 32'sd0;
			nxt_q  <= 32'sd0;
		end
		if (cmd.load) at_q <= item.y;
		if (cmd.advance) at_q <= nxt_q;
		yend_q <= (cmd.advance ? nxt_q : at_q) + h_eff;
		if (cmd.scan_step && rd_vld_q) begin
			if (rd_q.y1 > at_q && rd_q.y0 < yend_q) begin
				if (!rd_q.right) begin
					if (rd_q.x1 > lo_q) lo_q <= rd_q.x1;
				end else if (rd_q.x0 < hi_q) hi_q <= rd_q.x0;
			end
			if (it_q.kind == fpt_pkg::KIND_CLEAR) begin
				if (want && rd_q.y1 > mx_q) mx_q <= rd_q.y1;
			end else if (rd_q.y1 > mx_q) mx_q <= rd_q.y1;
			if (rd_q.y1 > at_q && (nxt_q == 32'sd0 || rd_q.y1 < nxt_q)) nxt_q <= rd_q.y1;
		end
		if (cmd.finish) res <= res_c;
		if (cmd.finish && it_q.kind == fpt_pkg::KIND_PLACE &&
		    cnt_q < fpt_pkg::CNT_BITS'(fpt_pkg::MAX_FLOATS)) begin
			mem[cnt_q[fpt_pkg::IDX_BITS-1:0]] <= '{x0: px_c - it_q.ml,
				x1: px_c + it_q.bw + it_q.mr, y0: at_q, y1: at_q + oh_q, right: it_q.right};
		end
	end

	// scan index; read data arrives in the cycle after its index is presented
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			idx_q    <= '0;
			tries_q  <= '0;
			rd_vld_q <= 1'b0;
			cl_q     <= '0;
			cr_q     <= '0;
		end else begin
			if (cfg_en) begin
				if (cfg_addr == fpt_pkg::CFG_LEFT) cl_q <= cfg_data;
				else cr_q <= cfg_data;
			end
			rd_vld_q <= rd_go;
			if (cmd.scan_start) idx_q <= fpt_pkg::CNT_BITS'(rd_go);
			else if (cmd.scan_step && rd_go) idx_q <= idx_q + 1'b1;
			if (cmd.load) tries_q <= '0;
			else if (cmd.advance) tries_q <= tries_q + 1'b1;
			if (cmd.clear_cnt) cnt_q <= '0;
			else if (cmd.finish && it_q.kind == fpt_pkg::KIND_PLACE &&
			         cnt_q < fpt_pkg::CNT_BITS'(fpt_pkg::MAX_FLOATS))
				cnt_q <= cnt_q + 1'b1;
		end
	end

	assign st.kind       = it_q.kind;
	assign st.scan_last  = cmd.scan_step && !rd_go;
	assign st.fits       = (wid_c >= ow_q);
	assign st.no_next    = (nxt_q == 32'sd0);
	assign st.tries_done = (tries_q >= cnt_q);

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= fpt_pkg::CNT_BITS'(fpt_pkg::MAX_FLOATS)) else $error("count overflow");
	a_idx_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= cnt_q || cmd.clear_cnt || $past(cmd.clear_cnt)) else $error("index past count");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> cnt_q == '0 || cnt_q == $past(cnt_q) + 1'b1)
		else $error("count jump");

endmodule

// ===== hdl/float_placement_table_unit.sv =====
// ----------------------------------------------------------------------------
// float_placement_table_unit
// table of floated margin boxes with band, clear, bottom, place and empty operations
// ----------------------------------------------------------------------------
// One transaction at a time. A query passes through accept, decode, a scan
// that reads one table entry per cycle from the single-port float store,
// result and hand-off. A place repeats a band scan per candidate y, up to
// count+1 scans. The next item is taken once the result register has been
// handed off. Table storage is undefined until written; only the fill count
// is reset.
module float_placement_table_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: kind[2:0], y_position, probe_height, box_width[30:0], box_height[30:0],
	// margin_left, margin_right, margin_top, margin_bottom, side, clear_sides, pad
	input  logic [263:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: band_left, band_right, edge_y, place_x, place_y, recorded, pad
	output logic [167:0] m_tdata
);

	fpt_pkg::cmd_t    cmd;
	fpt_pkg::stat_t   st;
	fpt_pkg::item_t   item;
	fpt_pkg::result_t res;
	logic idle, res_set, in_fire, ovld_q;

	assign s_tready = idle && !ovld_q;
	assign in_fire  = s_tvalid && s_tready;

	// unpack input transaction
	assign item.kind  = s_tdata[2:0];
	assign item.y     = s_tdata[34:3];
	assign item.ph    = s_tdata[66:35];
	assign item.bw    = {1'b0, s_tdata[97:67]};
	assign item.bh    = {1'b0, s_tdata[128:98]};
	assign item.ml    = s_tdata[160:129];
	assign item.mr    = s_tdata[192:161];
	assign item.mt    = s_tdata[224:193];
	assign item.mb    = s_tdata[256:225];
	assign item.right = s_tdata[257];
	assign item.mask  = s_tdata[259:258];

	fpt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_busy(ovld_q),
		.st(st), .cmd(cmd), .idle(idle), .res_set(res_set)
	);

	fpt_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .item(item),
		.cfg_en(cfg_we), .cfg_addr(cfg_index), .cfg_data(cfg_data),
		.st(st), .res(res)
	);

	// output valid rises at the same edge that loads the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovld_q <= 1'b0;
		else if (res_set) ovld_q <= 1'b1;
		else if (m_tready) ovld_q <= 1'b0;
	end

	assign m_tvalid = ovld_q;
	assign m_tdata  = {7'd0, res.recorded, res.place_y, res.place_x, res.edge_y,
	                   res.band_right, res.band_left};

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("accept while result pending");

endmodule
